[rtl/tpr_pkg.sv]
// Shared types and constants of the track plane resampler.
// Used by tpr_ctrl, tpr_dp and track_plane_resampler; depends on nothing.
package tpr_pkg;

    localparam int MAX_POINTS_DEF  = 1024;
    localparam int MAX_SAMPLES_DEF = 64;

    // distance accumulator width (three products plus a 48 bit offset)
    localparam int DW = 52;
    localparam int FB = 16;

    localparam int IN_W  = 176;
    localparam int OUT_W = 72;
    localparam int CFG_W = 48;
    localparam int CIX_W = 3;

    // input tdata layout
    localparam int IDX_LO  = 0;
    localparam int NRM_LO  = 6;
    localparam int OFF_LO  = 54;
    localparam int PT_LO   = 102;

    localparam logic [CIX_W-1:0] CFG_START_NORMAL = 3'd0;
    localparam logic [CIX_W-1:0] CFG_START_OFFSET = 3'd1;
    localparam logic [CIX_W-1:0] CFG_MID_NORMAL   = 3'd2;
    localparam logic [CIX_W-1:0] CFG_MID_OFFSET   = 3'd3;
    localparam logic [CIX_W-1:0] CFG_END_NORMAL   = 3'd4;
    localparam logic [CIX_W-1:0] CFG_END_OFFSET   = 3'd5;
    localparam logic [CIX_W-1:0] CFG_SAMPLE_COUNT = 3'd6;

    localparam logic [47:0] RST_NORMAL     = 48'h4000_0000_0000;
    localparam logic [47:0] RST_START_OFF  = 48'hFFFF_F380_0000;
    localparam logic [47:0] RST_MID_OFF    = 48'h0;
    localparam logic [47:0] RST_END_OFF    = 48'h0000_0C80_0000;
    localparam logic [6:0]  RST_SAMPLES    = 7'd64;

    typedef enum logic [1:0] {
        NS_START = 2'd0,
        NS_MID   = 2'd1,
        NS_END   = 2'd2,
        NS_TBL   = 2'd3
    } t_nsel;

    typedef struct packed {
        logic       tbl_wr;
        logic       pt_load;
        logic       pc_sat;
        logic       mac_en;
        logic       first;
        logic [1:0] comp;
        t_nsel      nsel;
        logic       csel_buf;
        logic       latch_cur;
        logic       classify;
        logic       clear;
        logic       walk_init;
        logic       rd_cur;
        logic       rd_nb;
        logic       tbl_rd;
        logic       save_d;
        logic       div_start;
        logic       i_step;
        logic       n_inc;
        logic       interp_en;
        logic       push;
        logic       final_out;
    } t_cmd;

    typedef struct packed {
        logic pt_full;
        logic walk_go;
        logic d_pos;
        logic usable;
        logic n_done;
        logic div_busy;
        logic out_full;
        logic pend_vld;
    } t_sts;

endpackage

[rtl/tpr_ctrl.sv]
// Sequencer of the track plane resampler: point intake, classification and plane walk.
// Depends on tpr_pkg; drives tpr_dp through t_cmd and reads back t_sts.
module tpr_ctrl
    import tpr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_func,
    input  logic i_last,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_PEVAL  = 14'b00000000000010,
        ST_PCLS   = 14'b00000000000100,
        ST_WINIT  = 14'b00000000001000,
        ST_TBL    = 14'b00000000010000,
        ST_CHK    = 14'b00000000100000,
        ST_CMAC   = 14'b00000001000000,
        ST_CD     = 14'b00000010000000,
        ST_NMAC   = 14'b00000100000000,
        ST_DSTART = 14'b00001000000000,
        ST_DIV    = 14'b00010000000000,
        ST_INT    = 14'b00100000000000,
        ST_PUSH   = 14'b01000000000000,
        ST_FLUSH  = 14'b10000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_comp, n_comp;
    logic [1:0] r_pl, n_pl;
    logic       r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_comp  <= 2'd0;
            r_pl    <= 2'd0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_comp  <= n_comp;
            r_pl    <= n_pl;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_comp  = r_comp;
        n_pl    = r_pl;
        n_last  = r_last;
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.comp = r_comp;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (!i_func) begin
                        o_cmd.tbl_wr = 1'b1;
                    end else begin
                        n_last = i_last;
                        if (i_sts.pt_full) begin
                            // overflowed track: drop the point
                            o_cmd.pc_sat = 1'b1;
                            n_state = i_last ? ST_WINIT : ST_IDLE;
                        end else begin
                            o_cmd.pt_load = 1'b1;
                            n_comp  = 2'd0;
                            n_pl    = 2'd0;
                            n_state = ST_PEVAL;
                        end
                    end
                end
            end
            ST_PEVAL: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.first  = (r_comp == 2'd0);
                case (r_pl)
                    2'd0:    o_cmd.nsel = NS_START;
                    2'd1:    o_cmd.nsel = NS_MID;
                    default: o_cmd.nsel = NS_END;
                endcase
                if (r_comp == 2'd2) begin
                    n_comp = 2'd0;
                    if (r_pl == 2'd2) begin
                        n_state = ST_PCLS;
                    end else begin
                        n_pl = r_pl + 2'd1;
                    end
                end else begin
                    n_comp = r_comp + 2'd1;
                end
            end
            ST_PCLS: begin
                o_cmd.classify = 1'b1;
                n_state = r_last ? ST_WINIT : ST_IDLE;
            end
            ST_WINIT: begin
                o_cmd.walk_init = 1'b1;
                n_state = i_sts.usable ? ST_TBL : ST_FLUSH;
            end
            ST_TBL: begin
                if (i_sts.n_done) begin
                    n_state = ST_FLUSH;
                end else begin
                    o_cmd.tbl_rd = 1'b1;
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (!i_sts.walk_go) begin
                    n_state = ST_FLUSH;
                end else begin
                    o_cmd.rd_cur = 1'b1;
                    n_comp  = 2'd0;
                    n_state = ST_CMAC;
                end
            end
            ST_CMAC, ST_NMAC: begin
                o_cmd.mac_en    = 1'b1;
                o_cmd.first     = (r_comp == 2'd0);
                o_cmd.nsel      = NS_TBL;
                o_cmd.csel_buf  = 1'b1;
                o_cmd.latch_cur = (r_state == ST_CMAC) && (r_comp == 2'd0);
                if (r_comp == 2'd2) begin
                    n_comp  = 2'd0;
                    n_state = (r_state == ST_CMAC) ? ST_CD : ST_DSTART;
                end else begin
                    n_comp = r_comp + 2'd1;
                end
            end
            ST_CD: begin
                if (i_sts.d_pos) begin
                    o_cmd.save_d = 1'b1;
                    o_cmd.rd_nb  = 1'b1;
                    n_comp  = 2'd0;
                    n_state = ST_NMAC;
                end else begin
                    o_cmd.i_step = 1'b1;
                    n_state = ST_CHK;
                end
            end
            ST_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (!i_sts.div_busy) begin
                    n_comp  = 2'd0;
                    n_state = ST_INT;
                end
            end
            ST_INT: begin
                o_cmd.interp_en = 1'b1;
                if (r_comp == 2'd2) begin
                    n_comp  = 2'd0;
                    n_state = ST_PUSH;
                end else begin
                    n_comp = r_comp + 2'd1;
                end
            end
            ST_PUSH: begin
                // hold the new crossing until the older one can leave
                if (!(i_sts.pend_vld && i_sts.out_full)) begin
                    o_cmd.push  = 1'b1;
                    o_cmd.n_inc = 1'b1;
                    n_state = ST_TBL;
                end
            end
            ST_FLUSH: begin
                if (!i_sts.out_full) begin
                    o_cmd.final_out = 1'b1;
                    o_cmd.clear     = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/tpr_dp.sv]
// Datapath of the track plane resampler: config registers, point buffer, plane table,
// multiply-accumulate distance unit, weight divider, interpolator and output register.
// Depends on tpr_pkg; commanded by tpr_ctrl.
module tpr_dp
    import tpr_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CIX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic [IN_W-1:0]  i_tdata,
    input  logic             i_m_tready,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    output logic             o_ovld,
    output logic [OUT_W-1:0] o_odata,
    output logic             o_olast,
    output logic             o_oskip
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 2);
    localparam int TW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int NW = $clog2(MAX_SAMPLES + 1);

    // configuration
    logic [47:0] r_sn, r_so, r_mn, r_mo, r_en, r_eo;
    logic [6:0]  r_sc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sn <= RST_NORMAL;
            r_so <= RST_START_OFF;
            r_mn <= RST_NORMAL;
            r_mo <= RST_MID_OFF;
            r_en <= RST_NORMAL;
            r_eo <= RST_END_OFF;
            r_sc <= RST_SAMPLES;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_NORMAL: r_sn <= i_cfg_data;
                CFG_START_OFFSET: r_so <= i_cfg_data;
                CFG_MID_NORMAL:   r_mn <= i_cfg_data;
                CFG_MID_OFFSET:   r_mo <= i_cfg_data;
                CFG_END_NORMAL:   r_en <= i_cfg_data;
                CFG_END_OFFSET:   r_eo <= i_cfg_data;
                CFG_SAMPLE_COUNT: r_sc <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    logic [NW-1:0] w_np;
    assign w_np = (r_sc > 7'(MAX_SAMPLES)) ? NW'(MAX_SAMPLES) : NW'(r_sc);

    // plane table memory
    logic [95:0] r_tbl_mem [MAX_SAMPLES];
    logic [95:0] r_tbl;
    logic [NW-1:0] r_n;
    logic [5:0]  w_lidx;
    assign w_lidx = i_tdata[IDX_LO +: 6];

    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_wr && ({1'b0, w_lidx} < 7'(MAX_SAMPLES))) begin
            r_tbl_mem[w_lidx[TW-1:0]] <= {i_tdata[OFF_LO +: 48], i_tdata[NRM_LO +: 48]};
        end
        if (i_cmd.tbl_rd) begin
            r_tbl <= r_tbl_mem[r_n[TW-1:0]];
        end
    end

    // point buffer memory, {z, y, x}
    logic [71:0] r_buf [MAX_POINTS];
    logic [71:0] r_rd, r_pt, r_cur;
    logic [CW-1:0] r_pc, r_i, r_endi;
    logic          r_rev;
    logic [CW-1:0] w_nb_raw, w_nb;

    assign w_nb_raw = r_rev ? (r_i + CW'(1)) : (r_i - CW'(1));
    assign w_nb     = (w_nb_raw >= r_pc) ? r_i : w_nb_raw;

    always_ff @(posedge i_clk) begin
        if (i_cmd.pt_load) begin
            r_buf[r_pc[AW-1:0]] <= i_tdata[PT_LO +: 72];
            r_pt <= i_tdata[PT_LO +: 72];
        end
        if (i_cmd.rd_cur) begin
            r_rd <= r_buf[r_i[AW-1:0]];
        end else if (i_cmd.rd_nb) begin
            r_rd <= r_buf[w_nb[AW-1:0]];
        end
        if (i_cmd.latch_cur) begin
            r_cur <= r_rd;
        end
    end

    // distance multiply-accumulate, one component per cycle
    logic [47:0]          w_nrm, w_off;
    logic [71:0]          w_cw;
    logic signed [15:0]   w_nc;
    logic signed [23:0]   w_cc;
    logic signed [39:0]   w_prod;
    logic signed [DW-1:0] r_acc, r_da, r_dm, r_d, w_base;

    always_comb begin
        case (i_cmd.nsel)
            NS_START: begin w_nrm = r_sn; w_off = r_so; end
            NS_MID:   begin w_nrm = r_mn; w_off = r_mo; end
            NS_END:   begin w_nrm = r_en; w_off = r_eo; end
            default:  begin w_nrm = r_tbl[47:0]; w_off = r_tbl[95:48]; end
        endcase
        w_cw = i_cmd.csel_buf ? r_rd : r_pt;
        case (i_cmd.comp)
            2'd0:    begin w_nc = w_nrm[15:0];  w_cc = w_cw[23:0];  end
            2'd1:    begin w_nc = w_nrm[31:16]; w_cc = w_cw[47:24]; end
            default: begin w_nc = w_nrm[47:32]; w_cc = w_cw[71:48]; end
        endcase
        w_prod = w_nc * w_cc;
        w_base = i_cmd.first ? -DW'($signed(w_off)) : r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_en) begin
            r_acc <= w_base + DW'(w_prod);
            if (i_cmd.first && (i_cmd.nsel == NS_MID)) begin
                r_da <= r_acc;
            end
            if (i_cmd.first && (i_cmd.nsel == NS_END)) begin
                r_dm <= r_acc;
            end
        end
        if (i_cmd.save_d) begin
            r_d <= r_acc;
        end
    end

    // classification and segment search
    logic [1:0]    r_prev, w_cls;
    logic [AW-1:0] r_cs, r_ce, r_bs, r_be;
    logic [AW-1:0] w_cs, w_ce, w_pi, w_spc, w_spb;
    logic          w_as, w_am, w_ae;

    always_comb begin
        w_as = !r_da[DW-1];
        w_am = !r_dm[DW-1] && (r_dm != '0);
        w_ae = !r_acc[DW-1];
        if (!w_as && !w_am)      w_cls = 2'd0;
        else if (w_as && !w_am)  w_cls = 2'd1;
        else if (w_am && !w_ae)  w_cls = 2'd2;
        else                     w_cls = 2'd3;
        w_pi = r_pc[AW-1:0];
        w_cs = r_cs;
        w_ce = r_ce;
        if (r_prev == 2'd0 && w_cls == 2'd1) w_cs = w_pi - AW'(1);
        if (r_prev == 2'd1 && w_cls == 2'd0) w_cs = w_pi;
        if (r_prev == 2'd2 && w_cls == 2'd3) w_ce = w_pi;
        if (r_prev == 2'd3 && w_cls == 2'd2) w_ce = w_pi - AW'(1);
        w_spc = (w_ce >= w_cs) ? (w_ce - w_cs) : (w_cs - w_ce);
        w_spb = (r_be >= r_bs) ? (r_be - r_bs) : (r_bs - r_be);
    end

    // weight divider, one quotient bit per cycle
    logic [DW:0]          r_rem, w_t;
    logic signed [DW-1:0] r_den, w_den;
    logic [FB:0]          r_q;
    logic [4:0]           r_dcnt;

    assign w_den = r_d - r_acc;
    assign w_t   = {r_rem[DW-1:0], 1'b0};

    // interpolation
    logic [71:0]        r_res, r_pend;
    logic               r_pend_vld;
    logic               r_ovld;
    logic signed [23:0] w_cur_c, w_nb_c;
    logic signed [24:0] w_diff;
    logic signed [42:0] w_iv;
    logic [23:0]        w_ires;

    always_comb begin
        case (i_cmd.comp)
            2'd0:    begin w_cur_c = r_cur[23:0];  w_nb_c = r_rd[23:0];  end
            2'd1:    begin w_cur_c = r_cur[47:24]; w_nb_c = r_rd[47:24]; end
            default: begin w_cur_c = r_cur[71:48]; w_nb_c = r_rd[71:48]; end
        endcase
        w_diff = 25'(w_nb_c) - 25'(w_cur_c);
        w_iv   = w_diff * $signed({1'b0, r_q}) + 43'sd32768;
        w_ires = 24'(w_cur_c + 24'(w_iv >>> FB));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.interp_en) begin
            case (i_cmd.comp)
                2'd0:    r_res[23:0]  <= w_ires;
                2'd1:    r_res[47:24] <= w_ires;
                default: r_res[71:48] <= w_ires;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= '0;
            r_prev     <= 2'd0;
            r_cs       <= '0;
            r_ce       <= '0;
            r_bs       <= '0;
            r_be       <= '0;
            r_i        <= '0;
            r_endi     <= '0;
            r_rev      <= 1'b0;
            r_n        <= '0;
            r_dcnt     <= '0;
            r_pend_vld <= 1'b0;
            r_ovld     <= 1'b0;
        end else begin
            if (i_cmd.pc_sat) begin
                r_pc <= CW'(MAX_POINTS + 1);
            end
            if (i_cmd.classify) begin
                if (r_pc != '0) begin
                    if (w_cs != '0 && w_ce != '0) begin
                        if (w_spc > w_spb) begin
                            r_bs <= w_cs;
                            r_be <= w_ce;
                        end
                        r_cs <= '0;
                        r_ce <= '0;
                    end else begin
                        r_cs <= w_cs;
                        r_ce <= w_ce;
                    end
                end
                r_prev <= w_cls;
                r_pc   <= r_pc + CW'(1);
            end
            if (i_cmd.walk_init) begin
                r_i        <= CW'(r_bs);
                r_endi     <= CW'(r_be) + CW'(1);
                r_rev      <= CW'(r_bs) > (CW'(r_be) + CW'(1));
                r_n        <= '0;
                r_pend_vld <= 1'b0;
            end
            if (i_cmd.i_step) begin
                r_i <= r_rev ? (r_i - CW'(1)) : (r_i + CW'(1));
            end
            if (i_cmd.n_inc) begin
                r_n <= r_n + NW'(1);
            end
            if (i_cmd.div_start) begin
                r_rem <= {1'b0, r_d};
                r_den <= w_den;
                if (w_den[DW-1] || w_den == '0) begin
                    r_q    <= '0;
                    r_dcnt <= '0;
                end else if (r_d >= w_den) begin
                    r_q    <= (FB+1)'(1) << FB;
                    r_dcnt <= '0;
                end else begin
                    r_q    <= '0;
                    r_dcnt <= 5'(FB);
                end
            end else if (r_dcnt != '0) begin
                if (w_t >= {1'b0, r_den}) begin
                    r_rem <= w_t - {1'b0, r_den};
                    r_q   <= {r_q[FB-1:0], 1'b1};
                end else begin
                    r_rem <= w_t;
                    r_q   <= {r_q[FB-1:0], 1'b0};
                end
                r_dcnt <= r_dcnt - 5'd1;
            end
            // load a new result or drop the one the receiver took
            if (i_cmd.final_out || (i_cmd.push && r_pend_vld)) begin
                r_ovld <= 1'b1;
            end else if (i_m_tready) begin
                r_ovld <= 1'b0;
            end
            if (i_cmd.push) begin
                if (r_pend_vld) begin
                    o_odata <= r_pend;
                    o_olast <= 1'b0;
                    o_oskip <= 1'b0;
                end
                r_pend     <= r_res;
                r_pend_vld <= 1'b1;
            end
            if (i_cmd.final_out) begin
                o_odata <= r_pend_vld ? r_pend : '0;
                o_olast <= 1'b1;
                o_oskip <= !r_pend_vld;
            end
            if (i_cmd.clear) begin
                r_pc       <= '0;
                r_prev     <= 2'd0;
                r_cs       <= '0;
                r_ce       <= '0;
                r_bs       <= '0;
                r_be       <= '0;
                r_pend_vld <= 1'b0;
            end
        end
    end

    assign o_ovld = r_ovld;

    always_comb begin
        o_sts.pt_full  = (r_pc >= CW'(MAX_POINTS));
        o_sts.walk_go  = (r_i != r_endi) && (r_i < r_pc);
        o_sts.d_pos    = !r_acc[DW-1] && (r_acc != '0);
        o_sts.usable   = (r_pc <= CW'(MAX_POINTS)) && (r_bs != '0) && (w_np != '0);
        o_sts.n_done   = (r_n >= w_np);
        o_sts.div_busy = (r_dcnt != '0);
        o_sts.out_full = r_ovld && !i_m_tready;
        o_sts.pend_vld = r_pend_vld;
    end

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.final_out || (i_cmd.push && r_pend_vld)) |-> !(r_ovld && !i_m_tready))
        else $error("result loaded over a waiting result");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> (r_dcnt == '0))
        else $error("divider restarted while busy");
    a_pc_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.classify |=> (r_pc != '0))
        else $error("point count did not advance");
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && o_oskip) |-> (o_odata == '0 && o_olast))
        else $error("skipped result carries data");
`endif

endmodule

[rtl/track_plane_resampler.sv]
// Top level of the track plane resampler: stream ports, config port, sequencer and datapath.
// Depends on tpr_pkg, tpr_ctrl and tpr_dp.
//
// Usage: the slave stream carries items; tuser = 0 loads plane table entry plane_index,
// tuser = 1 delivers a track point, tlast marks the track's last point. Results leave on
// the master stream: one per plane crossing, tlast on the last one of a track; a track
// with no usable segment or crossing gives a single result with tuser set and zero data.
// Configuration registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
// A plane load is a single table write. A point is accepted, then its three half-space
// distances run on the single 16x24 multiply-accumulate unit, and then it is classified.
// After the last point the plane walk visits buffer points one by one, each with a buffer
// read and a three-component distance on the MAC; each crossing adds the neighbor distance,
// the restoring divider for the weight, interpolation of each component and a table read.
// The single buffer read port and the shared MAC serialize these steps.
// Reset (synchronous, active low) empties the track, restores register defaults and
// drops any waiting result; buffer and plane table contents are not cleared.
// A stalled receiver holds the output register; the walk pauses once one crossing is
// waiting behind it, and no item is accepted until the track's results are all queued.
module track_plane_resampler
    import tpr_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // plane_index, normal_x, normal_y, normal_z, plane_offset, point_x, point_y,
    // point_z, 2 zero bits
    input  logic [IN_W-1:0]  s_axis_tdata,
    // func
    input  logic             s_axis_tuser,
    input  logic             s_axis_tlast,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // out_x, out_y, out_z
    output logic [OUT_W-1:0] m_axis_tdata,
    // track_skipped
    output logic             m_axis_tuser,
    output logic             m_axis_tlast,
    input  logic             i_cfg_we,
    input  logic [CIX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    tpr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_func  (s_axis_tuser),
        .i_last  (s_axis_tlast),
        .o_ready (s_axis_tready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    tpr_dp #(
        .MAX_POINTS  (MAX_POINTS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_tdata    (s_axis_tdata),
        .i_m_tready (m_axis_tready),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_ovld     (m_axis_tvalid),
        .o_odata    (m_axis_tdata),
        .o_olast    (m_axis_tlast),
        .o_oskip    (m_axis_tuser)
    );

endmodule

[sim/tpr_scoreboard.sv]
// Scoreboard of the track plane resampler: classifies points, picks the track
// segment and predicts each plane crossing. Depends on tpr_pkg.
`timescale 1ns / 100ps

package tpr_tb_pkg;
    import tpr_pkg::*;

    localparam int BUF_DEPTH = 1024;
    localparam int TBL_DEPTH = 64;

    typedef struct {
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] z;
        logic        last;
        logic        skip;
    } t_crossing;

    class tpr_scoreboard;
        logic [47:0] start_nrm, start_off, mid_nrm, mid_off, end_nrm, end_off;
        logic [6:0]  samples;
        longint      pt_x[BUF_DEPTH], pt_y[BUF_DEPTH], pt_z[BUF_DEPTH];
        logic [47:0] tbl_nrm[TBL_DEPTH], tbl_off[TBL_DEPTH];
        int unsigned n_pts, last_cls, cand_s, cand_e, best_s, best_e;
        t_crossing   crossings_q[$];
        int          mismatches;

        function new();
            start_nrm = RST_NORMAL;
            mid_nrm   = RST_NORMAL;
            end_nrm   = RST_NORMAL;
            start_off = RST_START_OFF;
            mid_off   = RST_MID_OFF;
            end_off   = RST_END_OFF;
            samples   = RST_SAMPLES;
            mismatches = 0;
            clear_track();
        endfunction

        function void clear_track();
            n_pts = 0;
            last_cls = 0;
            cand_s = 0;
            cand_e = 0;
            best_s = 0;
            best_e = 0;
        endfunction

        function void write_reg(logic [CIX_W-1:0] idx, logic [47:0] val);
            case (idx)
                CFG_START_NORMAL: start_nrm = val;
                CFG_START_OFFSET: start_off = val;
                CFG_MID_NORMAL:   mid_nrm = val;
                CFG_MID_OFFSET:   mid_off = val;
                CFG_END_NORMAL:   end_nrm = val;
                CFG_END_OFFSET:   end_off = val;
                CFG_SAMPLE_COUNT: samples = val[6:0];
                default: ;
            endcase
        endfunction

        function longint plane_dist(logic [47:0] nrm, logic [47:0] off,
                                    longint x, longint y, longint z);
            return longint'($signed(nrm[15:0])) * x + longint'($signed(nrm[31:16])) * y
                 + longint'($signed(nrm[47:32])) * z - longint'($signed(off));
        endfunction

        function longint tbl_dist(int unsigned n, int unsigned i);
            return plane_dist(tbl_nrm[n], tbl_off[n], pt_x[i], pt_y[i], pt_z[i]);
        endfunction

        // truncating restoring division, weight in unsigned Q1.16
        function longint weight(longint d, longint den);
            longint unsigned r, q;
            if (den <= 0 || d <= 0) return 0;
            if (d >= den) return 65536;
            r = d;
            q = 0;
            for (int k = 0; k < FB; k++) begin
                r = r << 1;
                q = q << 1;
                if (r >= longint'(den)) begin
                    r = r - den;
                    q = q | 1;
                end
            end
            return q;
        endfunction

        function logic [23:0] lerp(longint cur, longint nb, longint f);
            longint v;
            v = (nb - cur) * f + 32768;
            return 24'(cur + (v >>> FB));
        endfunction

        function void add_point(longint x, longint y, longint z);
            int unsigned i, cls;
            longint span_c, span_b;
            bit as, am, ae;
            i = n_pts;
            if (i >= BUF_DEPTH) begin
                n_pts = BUF_DEPTH + 1;
                return;
            end
            pt_x[i] = x;
            pt_y[i] = y;
            pt_z[i] = z;
            as = plane_dist(start_nrm, start_off, x, y, z) >= 0;
            am = plane_dist(mid_nrm, mid_off, x, y, z) > 0;
            ae = plane_dist(end_nrm, end_off, x, y, z) >= 0;
            if (!as && !am) cls = 0;
            else if (as && !am) cls = 1;
            else if (am && !ae) cls = 2;
            else cls = 3;
            if (i > 0) begin
                if (last_cls == 0 && cls == 1) cand_s = i - 1;
                if (last_cls == 1 && cls == 0) cand_s = i;
                if (last_cls == 2 && cls == 3) cand_e = i;
                if (last_cls == 3 && cls == 2) cand_e = i - 1;
                if (cand_s != 0 && cand_e != 0) begin
                    span_c = longint'(cand_e) - longint'(cand_s);
                    span_b = longint'(best_e) - longint'(best_s);
                    if (span_c < 0) span_c = -span_c;
                    if (span_b < 0) span_b = -span_b;
                    if (span_c > span_b) begin
                        best_s = cand_s;
                        best_e = cand_e;
                    end
                    cand_s = 0;
                    cand_e = 0;
                end
            end
            last_cls = cls;
            n_pts = i + 1;
        endfunction

        function void finish_track();
            int unsigned planes, i, stop, nb;
            bit rev;
            int cnt;
            longint d, f;
            t_crossing c;
            cnt = 0;
            planes = (samples > TBL_DEPTH) ? TBL_DEPTH : samples;
            if (n_pts <= BUF_DEPTH && best_s != 0) begin
                stop = best_e + 1;
                rev = best_s > stop;
                i = best_s;
                for (int unsigned n = 0; n < planes; n++) begin
                    while (i != stop && i < n_pts) begin
                        d = tbl_dist(n, i);
                        if (d > 0) begin
                            nb = rev ? i + 1 : i - 1;
                            if (nb >= n_pts) nb = i;
                            f = weight(d, d - tbl_dist(n, nb));
                            c.x = lerp(pt_x[i], pt_x[nb], f);
                            c.y = lerp(pt_y[i], pt_y[nb], f);
                            c.z = lerp(pt_z[i], pt_z[nb], f);
                            c.last = 1'b0;
                            c.skip = 1'b0;
                            crossings_q.insert(crossings_q.size(), c);
                            cnt++;
                            break;
                        end
                        i = rev ? i - 1 : i + 1;
                    end
                end
            end
            if (cnt == 0) begin
                c = '{24'd0, 24'd0, 24'd0, 1'b1, 1'b1};
                crossings_q.insert(crossings_q.size(), c);
            end else begin
                crossings_q[crossings_q.size() - 1].last = 1'b1;
            end
            clear_track();
        endfunction

        function void note_item(logic func, logic [IN_W-1:0] data, logic last);
            if (!func) begin
                tbl_nrm[data[IDX_LO +: 6]] = data[NRM_LO +: 48];
                tbl_off[data[IDX_LO +: 6]] = data[OFF_LO +: 48];
                return;
            end
            add_point(longint'($signed(data[PT_LO +: 24])),
                      longint'($signed(data[PT_LO + 24 +: 24])),
                      longint'($signed(data[PT_LO + 48 +: 24])));
            if (last) finish_track();
        endfunction

        function void check_result(logic [OUT_W-1:0] data, logic skip, logic last);
            t_crossing c;
            if (crossings_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result data=%h skip=%b last=%b", data, skip, last);
                return;
            end
            c = crossings_q.pop_front();
            if (data !== {c.z, c.y, c.x} || skip !== c.skip || last !== c.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("exp x=%h y=%h z=%h s=%b l=%b, got x=%h y=%h z=%h s=%b l=%b",
                             c.x, c.y, c.z, c.skip, c.last,
                             data[23:0], data[47:24], data[71:48], skip, last);
            end
        endfunction
    endclass
endpackage

[sim/testbench.sv]
// Testbench of track_plane_resampler: random-gap stream driver and receiver,
// checked against the scoreboard in tpr_tb_pkg. Depends on tpr_pkg and tpr_tb_pkg.
`timescale 1ns / 100ps

module testbench;
    import tpr_pkg::*;
    import tpr_tb_pkg::*;

    localparam logic FN_PLANE = 1'b0;
    localparam logic FN_POINT = 1'b1;
    localparam int   SETTLE = 60;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             s_axis_tuser = 1'b0;
    logic             s_axis_tlast = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             m_axis_tuser;
    logic             m_axis_tlast;
    logic             i_cfg_we = 1'b0;
    logic [CIX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    tpr_scoreboard sb = new();
    bit burst_mode = 1'b0;
    int rx_hold = 0;

    track_plane_resampler dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic send_item(logic func, logic [IN_W-1:0] data, logic last);
        int gap;
        if ($urandom_range(0, 19) == 0) burst_mode = !burst_mode;
        gap = burst_mode ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(func, data, last);
    endtask

    task automatic load_plane(logic [5:0] idx, logic signed [15:0] nx, logic signed [15:0] ny,
                              logic signed [15:0] nz, logic signed [47:0] off);
        send_item(FN_PLANE, {74'd0, off, nz, ny, nx, idx}, 1'b0);
    endtask

    // plane roughly perpendicular to z at height zp
    task automatic load_z_plane(logic [5:0] idx, int zp);
        logic signed [15:0] nx, ny;
        nx = $urandom_range(0, 1600) - 800;
        ny = $urandom_range(0, 1600) - 800;
        load_plane(idx, nx, ny, 16'sd16384, 48'(longint'(16384) * zp));
    endtask

    task automatic send_point(int x, int y, int z, logic last);
        send_item(FN_POINT, {2'b0, 24'(z), 24'(y), 24'(x), 102'd0}, last);
    endtask

    // sweep along z from one side of the start and end planes to the other
    task automatic sweep_track(int len, bit down);
        int z;
        for (int i = 0; i < len; i++) begin
            z = -16000 + (32000 * i) / (len - 1) + $urandom_range(0, 600) - 300;
            send_point($urandom_range(0, 8000) - 4000, $urandom_range(0, 8000) - 4000,
                       down ? -z : z, i == len - 1);
        end
    endtask

    task automatic noise_track(int len);
        for (int i = 0; i < len; i++)
            send_point($urandom, $urandom, $urandom, i == len - 1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.crossings_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CIX_W-1:0] idx, logic [47:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic set_regions(logic signed [15:0] nz, int zs, int zm, int ze, logic [6:0] cnt);
        cfg_write(CFG_START_NORMAL, {nz, 32'd0});
        cfg_write(CFG_START_OFFSET, 48'(longint'(nz) * zs));
        cfg_write(CFG_MID_NORMAL, {nz, 32'd0});
        cfg_write(CFG_MID_OFFSET, 48'(longint'(nz) * zm));
        cfg_write(CFG_END_NORMAL, {nz, 32'd0});
        cfg_write(CFG_END_OFFSET, 48'(longint'(nz) * ze));
        cfg_write(CFG_SAMPLE_COUNT, 48'(cnt));
    endtask

    task automatic random_phase(int items);
        int sent, len, pick;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30)
                                                  : $urandom_range(4, 10);
                sweep_track(len, $urandom_range(0, 1));
                sent += len;
            end else if (pick < 17) begin
                len = $urandom_range(1, 6);
                noise_track(len);
                sent += len;
            end else begin
                load_z_plane($urandom_range(0, 63), $urandom_range(0, 28000) - 14000);
                sent++;
            end
        end
        wait_drained();
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold) @(posedge i_clk);
                rx_hold = 0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // fill the whole plane table before any track can read it
        for (int n = 0; n < 64; n++) load_z_plane(n, -14000 + n * 400);
        wait_drained();

        // directed: two planes, extremes of the fields
        cfg_write(CFG_SAMPLE_COUNT, 48'd2);
        load_plane(6'd0, 16'sd0, 16'sd0, 16'sd16384, 48'(longint'(16384) * -2000));
        load_plane(6'd1, -16'sd16384, 16'sd0, -16'sd16384, 48'sh7FFF_FFFF_FFFF);
        load_plane(6'd1, 16'sd0, 16'sd0, -16'sd16384, 48'sh8000_0000_0000);
        sweep_track(6, 1'b0);
        sweep_track(6, 1'b1);
        send_point(0, 0, 0, 1'b1);                      // single point: skipped
        send_point(-8388608, 8388607, -8388608, 1'b0);  // no segment: skipped
        send_point(8388607, -8388608, -20000, 1'b1);
        // descending walk whose start is the last point: neighbor past the buffer
        send_point(10, 20, 16000, 1'b0);
        send_point(10, 20, 15000, 1'b0);
        send_point(30, 40, 5000, 1'b0);
        send_point(50, 60, -5000, 1'b0);
        send_point(70, 80, -15000, 1'b1);
        wait_drained();

        // defaults, all planes, one long receiver hold-off; the next track
        // is offered while the stalled walk blocks the input
        set_regions(16'sd16384, -12800, 0, 12800, 7'd64);
        rx_hold = 3000;
        sweep_track(20, 1'b0);
        sweep_track(6, 1'b1);
        wait_drained();
        random_phase(5);

        // mirrored regions, count above the table size
        set_regions(-16'sd16384, 12800, 0, -12800, 7'd127);
        random_phase(5);

        // extreme registers: everything on one side, no planes
        cfg_write(CFG_START_NORMAL, 48'hFFFF_FFFF_FFFF);
        cfg_write(CFG_START_OFFSET, 48'h7FFF_FFFF_FFFF);
        cfg_write(CFG_MID_NORMAL, 48'hFFFF_FFFF_FFFF);
        cfg_write(CFG_MID_OFFSET, 48'h8000_0000_0000);
        cfg_write(CFG_END_NORMAL, 48'h0);
        cfg_write(CFG_END_OFFSET, 48'h0);
        cfg_write(CFG_SAMPLE_COUNT, 48'd0);
        random_phase(4);

        set_regions(16'sd16384, -9000, 1000, 9000, 7'd2);
        random_phase(4);

        set_regions(16'sd16384, -12800, 0, 12800, 7'($urandom_range(3, 63)));
        random_phase(5);

        wait_drained();
        if (sb.mismatches == 0 && sb.crossings_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
